@@ rtl/scm_pkg.sv @@
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, codes and reset values of the stereo channel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

  localparam int DEF_MAX_CHANNELS   = 8;
  localparam int DEF_PAN_TABLE_SIZE = 256;

  localparam int CH_W       = 3;
  localparam int SMP_W      = 16;
  localparam int OUT_W      = 17;
  localparam int VOL_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int ACT_W      = 4;
  localparam int MASK_W     = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_MIX    = 2'd0,
    KIND_CHAN   = 2'd1,
    KIND_MASTER = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE  = 3'd0,
    REG_MUTE    = 3'd1,
    REG_SOLO    = 3'd2,
    REG_VOLUMES = 3'd3,
    REG_PANS    = 3'd4,
    REG_MASTER  = 3'd5
  } reg_idx_t;

  localparam logic [ACT_W-1:0]      RST_ACTIVE  = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_VOLUMES = 64'h8080_8080_8080_8080;
  localparam logic [CFG_DATA_W-1:0] RST_PANS    = 64'h0;
  localparam logic [VOL_W-1:0]      RST_MASTER  = 8'd128;

endpackage : scm_pkg

`default_nettype wire

@@ rtl/scm_gain_rom.sv @@
// ----------------------------------------------------------------------------
// scm_gain_rom
// Quarter-sine gain table with two registered read ports, Q1.15 entries.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_gain_rom #(
  parameter int PAN_TABLE_SIZE = scm_pkg::DEF_PAN_TABLE_SIZE
) (
  input  wire logic                                  clk,
  input  wire logic [$clog2(PAN_TABLE_SIZE+1)-1:0]   addr_a,
  input  wire logic [$clog2(PAN_TABLE_SIZE+1)-1:0]   addr_b,
  output logic      [scm_pkg::GAIN_W-1:0]            data_a,
  output logic      [scm_pkg::GAIN_W-1:0]            data_b
);
  import scm_pkg::*;

  // Entry k is sin(k*pi/(2*size)), evaluated by a fixed-point Taylor series
  // in Q2.30 and rounded to Q1.15.
  function automatic logic [GAIN_W-1:0] gain_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] acc;
    logic [63:0]        v;
    x   = (64'(k) * 64'd1686629713) / 64'(PAN_TABLE_SIZE);
    x2  = (x * x) >> 30;
    t   = x;
    acc = signed'(x);
    t   = ((t * x2) >> 30) / 64'd6;
    acc = acc - signed'(t);
    t   = ((t * x2) >> 30) / 64'd20;
    acc = acc + signed'(t);
    t   = ((t * x2) >> 30) / 64'd42;
    acc = acc - signed'(t);
    t   = ((t * x2) >> 30) / 64'd72;
    acc = acc + signed'(t);
    t   = ((t * x2) >> 30) / 64'd110;
    acc = acc - signed'(t);
    t   = ((t * x2) >> 30) / 64'd156;
    acc = acc + signed'(t);
    t   = ((t * x2) >> 30) / 64'd210;
    acc = acc - signed'(t);
    if (acc < 0) begin
      acc = '0;
    end
    v = (unsigned'(acc) + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[GAIN_W-1:0];
  endfunction

  logic [GAIN_W-1:0] gain_tab [PAN_TABLE_SIZE+1];

  for (genvar g = 0; g <= PAN_TABLE_SIZE; g++) begin : g_tab
    assign gain_tab[g] = gain_entry(g);
  end

  always_ff @(posedge clk) begin
    data_a <= gain_tab[addr_a];
    data_b <= gain_tab[addr_b];
  end

endmodule : scm_gain_rom

`default_nettype wire

@@ rtl/stereo_channel_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_channel_mixer_unit
// Constant-power stereo channel mixer with per-channel and master peak meters.
// ----------------------------------------------------------------------------
// Voice samples enter one channel item at a time on the in_ channel. Each
// non-silent channel is scaled by its volume and a pan gain from the sine
// table and added to a running stereo sum. The item flagged sample_end
// produces one mixed sample (sum times master volume, saturated to 16 bits);
// if it also carries frame_end it is followed by one peak report per channel
// and a master peak report, and the peaks are cleared. out_last marks the
// final result that an item causes. Registers are written on the cfg_ port,
// which is always ready; the user must write them only while the block is
// idle, and the block itself does not enforce it. After an item is accepted,
// the input stalls while the peak memory read, the volume-gain multiply, the
// sample multiply and the read-modify-write of the peak entry run one after
// another. A sample_end item adds the master multiply and saturation, and a
// frame end adds a memory read then the clearing write for each channel
// report, plus the master report. Results leave through an output register;
// while out_stall is high the result holds and the sequencer waits on it.
// After reset the block sweeps every peak memory entry to zero, with in_stall
// high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_channel_mixer_unit #(
  parameter int MAX_CHANNELS   = scm_pkg::DEF_MAX_CHANNELS,
  parameter int PAN_TABLE_SIZE = scm_pkg::DEF_PAN_TABLE_SIZE
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [scm_pkg::CH_W-1:0]   in_channel,
  input  wire logic signed [scm_pkg::SMP_W-1:0]  in_left_in,
  input  wire logic signed [scm_pkg::SMP_W-1:0]  in_right_in,
  input  wire logic                              in_sample_end,
  input  wire logic                              in_frame_end,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic             [scm_pkg::KIND_W-1:0] out_kind,
  output logic             [scm_pkg::CH_W-1:0]   out_report_channel,
  output logic signed      [scm_pkg::OUT_W-1:0]  out_left_out,
  output logic signed      [scm_pkg::OUT_W-1:0]  out_right_out,
  output logic                                   out_last,
  // configuration writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [scm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [scm_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import scm_pkg::*;

  localparam int KW      = $clog2(PAN_TABLE_SIZE + 1);
  localparam int PIDX_W  = KW + 8;
  localparam int CW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int MG_W    = VOL_W + GAIN_W;
  localparam int PROD_W  = SMP_W + MG_W + 1;
  localparam int SL_W    = PROD_W - 22;
  localparam int SUM_W   = 24;
  localparam int MPROD_W = SUM_W + VOL_W + 1;
  localparam int PK_W    = 16;

  localparam logic [ACT_W-1:0]    MAX_ACT  = ACT_W'(MAX_CHANNELS);
  localparam logic [CH_W-1:0]     LAST_CH  = CH_W'(MAX_CHANNELS - 1);
  localparam logic [KW-1:0]       TAB_TOP  = KW'(PAN_TABLE_SIZE);
  localparam logic [PK_W-1:0]     PK_LIMIT = 16'h8000;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7F_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh80_0000;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_GAIN, S_MUL, S_ACC, S_MST, S_SAT, S_RD, S_RPT, S_MRPT
  } state_t;

  function automatic logic silent_of(input logic [CH_W-1:0]   ch,
                                     input logic [ACT_W-1:0]  lim,
                                     input logic [MASK_W-1:0] mute,
                                     input logic [MASK_W-1:0] solo,
                                     input logic              any_solo);
    return ({1'b0, ch} >= lim) || mute[ch] || (any_solo && !solo[ch]);
  endfunction

  // Saturate a scaled sample magnitude to the peak range.
  function automatic logic [PK_W-1:0] peak_of(input logic signed [SL_W-1:0] v);
    logic [SL_W-1:0] mag;
    mag = (v < 0) ? unsigned'(-v) : unsigned'(v);
    return (mag > SL_W'(PK_LIMIT)) ? PK_LIMIT : mag[PK_W-1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  state_t                    state_r, state_nxt;
  logic [CH_W-1:0]           rpt_c_r, rpt_c_nxt;

  logic [ACT_W-1:0]          act_r, act_nxt;
  logic [MASK_W-1:0]         mute_r, mute_nxt;
  logic [MASK_W-1:0]         solo_r, solo_nxt;
  logic [CFG_DATA_W-1:0]     vols_r, vols_nxt;
  logic [CFG_DATA_W-1:0]     pans_r, pans_nxt;
  logic [VOL_W-1:0]          mvol_r, mvol_nxt;

  logic signed [SUM_W-1:0]   sum_l_r, sum_l_nxt;
  logic signed [SUM_W-1:0]   sum_r_r, sum_r_nxt;
  logic [PK_W-1:0]           mpk_l_r, mpk_l_nxt;
  logic [PK_W-1:0]           mpk_r_r, mpk_r_nxt;

  logic [CH_W-1:0]           ch_r, ch_nxt;
  logic signed [SMP_W-1:0]   l_r, l_nxt;
  logic signed [SMP_W-1:0]   r_r, r_nxt;
  logic                      se_r, se_nxt;
  logic                      fe_r, fe_nxt;
  logic                      silent_r, silent_nxt;
  logic [VOL_W-1:0]          vol_r, vol_nxt;
  logic [MG_W-1:0]           gl_r, gl_nxt;
  logic [MG_W-1:0]           gr_r, gr_nxt;
  logic signed [PROD_W-1:0]  pl_r, pl_nxt;
  logic signed [PROD_W-1:0]  pr_r, pr_nxt;
  logic signed [MPROD_W-1:0] mpl_r, mpl_nxt;
  logic signed [MPROD_W-1:0] mpr_r, mpr_nxt;

  logic                      out_valid_r, out_valid_nxt;
  kind_t                     out_kind_r, out_kind_nxt;
  logic [CH_W-1:0]           out_rc_r, out_rc_nxt;
  logic signed [OUT_W-1:0]   out_l_r, out_l_nxt;
  logic signed [OUT_W-1:0]   out_r_r, out_r_nxt;
  logic                      out_last_r, out_last_nxt;

  // ------------------------------------------------------------ peak memory
  // One entry per channel: left peak in the upper half, right in the lower.
  logic [2*PK_W-1:0] pk_mem [MAX_CHANNELS];
  logic [2*PK_W-1:0] pk_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [CW-1:0]     mem_waddr;
  logic [CW-1:0]     mem_raddr;
  logic [2*PK_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pk_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      pk_q_r <= pk_mem[mem_raddr];
    end
  end

  // ----------------------------------------------------------- silence logic
  logic [ACT_W-1:0]  limit;
  logic [MASK_W-1:0] below;
  logic              any_solo;

  always_comb begin
    limit = (act_r > MAX_ACT) ? MAX_ACT : act_r;
    for (int i = 0; i < MASK_W; i++) begin
      below[i] = (ACT_W'(i) < limit);
    end
    any_solo = |(solo_r & below);
  end

  // -------------------------------------------------------------- gain table
  logic [7:0]        pan_u;
  logic [PIDX_W-1:0] pidx;
  logic [KW-1:0]     k_right;
  logic [KW-1:0]     k_left;
  logic [GAIN_W-1:0] gain_r_q;
  logic [GAIN_W-1:0] gain_l_q;

  // The signed pan, made offset binary, selects the table index; left mirrors right.
  assign pan_u   = pans_r[{in_channel, 3'b000} +: 8] ^ 8'h80;
  assign pidx    = PIDX_W'(pan_u) * PIDX_W'(PAN_TABLE_SIZE);
  assign k_right = pidx[PIDX_W-1:8];
  assign k_left  = TAB_TOP - k_right;

  scm_gain_rom #(
    .PAN_TABLE_SIZE (PAN_TABLE_SIZE)
  ) u_gain_rom (
    .clk    (clk),
    .addr_a (k_right),
    .addr_b (k_left),
    .data_a (gain_r_q),
    .data_b (gain_l_q)
  );

  // ---------------------------------------------------------- sequencer
  logic                      in_ok;
  logic                      out_free;
  logic                      emit;
  logic signed [PROD_W-1:0]  sl_full, sr_full;
  logic signed [SL_W-1:0]    sl, sr;
  logic signed [SUM_W:0]     sum_l_w, sum_r_w;
  logic [PK_W-1:0]           al, ar;
  logic [PK_W-1:0]           pkl_new, pkr_new;
  logic signed [VOL_W:0]     mvol_s;
  logic signed [MPROD_W-1:0] ml_full, mr_full;
  logic signed [MPROD_W-8:0] ml_w, mr_w;
  logic signed [SMP_W-1:0]   ml_c, mr_c;
  logic signed [SMP_W:0]     ml_x, mr_x;
  logic [SMP_W:0]            ml_abs, mr_abs;
  logic                      rpt_silent;

  assign in_stall = (state_r != S_IDLE);
  assign in_ok    = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign mem_raddr = (state_r == S_IDLE) ? in_channel[CW-1:0] : rpt_c_r[CW-1:0];

  always_comb begin
    // rounding half up is an add then an arithmetic shift
    sl_full = pl_r + (PROD_W'(1) <<< 21);
    sr_full = pr_r + (PROD_W'(1) <<< 21);
    sl      = sl_full[PROD_W-1:22];
    sr      = sr_full[PROD_W-1:22];
    sum_l_w = (SUM_W+1)'(sum_l_r) + (SUM_W+1)'(sl);
    sum_r_w = (SUM_W+1)'(sum_r_r) + (SUM_W+1)'(sr);
    al      = peak_of(sl);
    ar      = peak_of(sr);
    pkl_new = (al > pk_q_r[2*PK_W-1:PK_W]) ? al : pk_q_r[2*PK_W-1:PK_W];
    pkr_new = (ar > pk_q_r[PK_W-1:0]) ? ar : pk_q_r[PK_W-1:0];

    mvol_s  = {1'b0, mvol_r};
    ml_full = mpl_r + MPROD_W'(64);
    mr_full = mpr_r + MPROD_W'(64);
    ml_w    = ml_full[MPROD_W-1:7];
    mr_w    = mr_full[MPROD_W-1:7];
    if (ml_w > (MPROD_W-7)'(32767)) begin
      ml_c = 16'sh7FFF;
    end else if (ml_w < -(MPROD_W-7)'(32768)) begin
      ml_c = -16'sh8000;
    end else begin
      ml_c = ml_w[SMP_W-1:0];
    end
    if (mr_w > (MPROD_W-7)'(32767)) begin
      mr_c = 16'sh7FFF;
    end else if (mr_w < -(MPROD_W-7)'(32768)) begin
      mr_c = -16'sh8000;
    end else begin
      mr_c = mr_w[SMP_W-1:0];
    end
    ml_x   = (SMP_W+1)'(ml_c);
    mr_x   = (SMP_W+1)'(mr_c);
    ml_abs = (ml_x < 0) ? unsigned'(-ml_x) : unsigned'(ml_x);
    mr_abs = (mr_x < 0) ? unsigned'(-mr_x) : unsigned'(mr_x);

    rpt_silent = silent_of(rpt_c_r, limit, mute_r, solo_r, any_solo);
  end

  always_comb begin
    state_nxt  = state_r;
    rpt_c_nxt  = rpt_c_r;
    act_nxt    = act_r;
    mute_nxt   = mute_r;
    solo_nxt   = solo_r;
    vols_nxt   = vols_r;
    pans_nxt   = pans_r;
    mvol_nxt   = mvol_r;
    sum_l_nxt  = sum_l_r;
    sum_r_nxt  = sum_r_r;
    mpk_l_nxt  = mpk_l_r;
    mpk_r_nxt  = mpk_r_r;
    ch_nxt     = ch_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    se_nxt     = se_r;
    fe_nxt     = fe_r;
    silent_nxt = silent_r;
    vol_nxt    = vol_r;
    gl_nxt     = gl_r;
    gr_nxt     = gr_r;
    pl_nxt     = pl_r;
    pr_nxt     = pr_r;
    mpl_nxt    = mpl_r;
    mpr_nxt    = mpr_r;
    out_kind_nxt = out_kind_r;
    out_rc_nxt   = out_rc_r;
    out_l_nxt    = out_l_r;
    out_r_nxt    = out_r_r;
    out_last_nxt = out_last_r;
    emit      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = rpt_c_r[CW-1:0];
    mem_wdata = '0;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE:  act_nxt  = cfg_data[ACT_W-1:0];
        REG_MUTE:    mute_nxt = cfg_data[MASK_W-1:0];
        REG_SOLO:    solo_nxt = cfg_data[MASK_W-1:0];
        REG_VOLUMES: vols_nxt = cfg_data;
        REG_PANS:    pans_nxt = cfg_data;
        REG_MASTER:  mvol_nxt = cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        rpt_c_nxt = rpt_c_r + 1'b1;
        if (rpt_c_r == LAST_CH) begin
          rpt_c_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_re = 1'b1;
        if (in_ok) begin
          ch_nxt     = in_channel;
          l_nxt      = in_left_in;
          r_nxt      = in_right_in;
          se_nxt     = in_sample_end;
          fe_nxt     = in_frame_end;
          silent_nxt = silent_of(in_channel, limit, mute_r, solo_r, any_solo);
          vol_nxt    = vols_r[{in_channel, 3'b000} +: 8];
          state_nxt  = S_GAIN;
        end
      end
      S_GAIN: begin
        gl_nxt    = MG_W'(vol_r) * MG_W'(gain_l_q);
        gr_nxt    = MG_W'(vol_r) * MG_W'(gain_r_q);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        pl_nxt    = PROD_W'(l_r) * PROD_W'(signed'({1'b0, gl_r}));
        pr_nxt    = PROD_W'(r_r) * PROD_W'(signed'({1'b0, gr_r}));
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!silent_r) begin
          if (sum_l_w[SUM_W] != sum_l_w[SUM_W-1]) begin
            sum_l_nxt = sum_l_w[SUM_W] ? SUM_MIN : SUM_MAX;
          end else begin
            sum_l_nxt = sum_l_w[SUM_W-1:0];
          end
          if (sum_r_w[SUM_W] != sum_r_w[SUM_W-1]) begin
            sum_r_nxt = sum_r_w[SUM_W] ? SUM_MIN : SUM_MAX;
          end else begin
            sum_r_nxt = sum_r_w[SUM_W-1:0];
          end
          mem_we    = 1'b1;
          mem_waddr = ch_r[CW-1:0];
          mem_wdata = {pkl_new, pkr_new};
        end
        state_nxt = se_r ? S_MST : S_IDLE;
      end
      S_MST: begin
        mpl_nxt   = MPROD_W'(sum_l_r) * MPROD_W'(mvol_s);
        mpr_nxt   = MPROD_W'(sum_r_r) * MPROD_W'(mvol_s);
        sum_l_nxt = '0;
        sum_r_nxt = '0;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_MIX;
          out_rc_nxt   = '0;
          out_l_nxt    = OUT_W'(ml_c);
          out_r_nxt    = OUT_W'(mr_c);
          out_last_nxt = !fe_r;
          if (ml_abs[PK_W-1:0] > mpk_l_r) begin
            mpk_l_nxt = ml_abs[PK_W-1:0];
          end
          if (mr_abs[PK_W-1:0] > mpk_r_r) begin
            mpk_r_nxt = mr_abs[PK_W-1:0];
          end
          rpt_c_nxt = '0;
          state_nxt = fe_r ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_RPT;
      end
      S_RPT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_CHAN;
          out_rc_nxt   = rpt_c_r;
          out_l_nxt    = rpt_silent ? '0 : signed'({1'b0, pk_q_r[2*PK_W-1:PK_W]});
          out_r_nxt    = rpt_silent ? '0 : signed'({1'b0, pk_q_r[PK_W-1:0]});
          out_last_nxt = 1'b0;
          mem_we       = 1'b1;
          if (rpt_c_r == LAST_CH) begin
            rpt_c_nxt = '0;
            state_nxt = S_MRPT;
          end else begin
            rpt_c_nxt = rpt_c_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_MRPT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_MASTER;
          out_rc_nxt   = '0;
          out_l_nxt    = signed'({1'b0, mpk_l_r});
          out_r_nxt    = signed'({1'b0, mpk_r_r});
          out_last_nxt = 1'b1;
          mpk_l_nxt    = '0;
          mpk_r_nxt    = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    se_r       <= se_nxt;
    fe_r       <= fe_nxt;
    silent_r   <= silent_nxt;
    vol_r      <= vol_nxt;
    gl_r       <= gl_nxt;
    gr_r       <= gr_nxt;
    pl_r       <= pl_nxt;
    pr_r       <= pr_nxt;
    mpl_r      <= mpl_nxt;
    mpr_r      <= mpr_nxt;
    out_kind_r <= out_kind_nxt;
    out_rc_r   <= out_rc_nxt;
    out_l_r    <= out_l_nxt;
    out_r_r    <= out_r_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_CLR;
      rpt_c_r     <= '0;
      act_r       <= RST_ACTIVE;
      mute_r      <= '0;
      solo_r      <= '0;
      vols_r      <= RST_VOLUMES;
      pans_r      <= RST_PANS;
      mvol_r      <= RST_MASTER;
      sum_l_r     <= '0;
      sum_r_r     <= '0;
      mpk_l_r     <= '0;
      mpk_r_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rpt_c_r     <= rpt_c_nxt;
      act_r       <= act_nxt;
      mute_r      <= mute_nxt;
      solo_r      <= solo_nxt;
      vols_r      <= vols_nxt;
      pans_r      <= pans_nxt;
      mvol_r      <= mvol_nxt;
      sum_l_r     <= sum_l_nxt;
      sum_r_r     <= sum_r_nxt;
      mpk_l_r     <= mpk_l_nxt;
      mpk_r_r     <= mpk_r_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_report_channel = out_rc_r;
  assign out_left_out       = out_l_r;
  assign out_right_out      = out_r_r;
  assign out_last           = out_last_r;

  // -------------------------------------------------------------- assertions
  // The master report always closes the results of its item.
  a_master_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_MASTER) |-> out_last_r)
    else $error("master peak report without last");

  // The stereo sum restarts from zero once a sample time is closed.
  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MST) |=> (sum_l_r == '0 && sum_r_r == '0))
    else $error("sum not cleared after sample end");

  // Issuing the master report clears the master peaks and frees the input.
  a_master_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRPT && out_free) |=>
      (state_r == S_IDLE && mpk_l_r == '0 && mpk_r_r == '0))
    else $error("master peaks not cleared at frame end");

endmodule : stereo_channel_mixer_unit

`default_nettype wire

@@ dv/stereo_channel_mixer_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_channel_mixer_unit_checker
// Follows the mixer's registers, running sums and peak meters from the
// accepted configuration writes and input items, and compares each accepted
// result field by field with the oldest one computed here.
// ----------------------------------------------------------------------------

module stereo_channel_mixer_unit_checker
  import scm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [CH_W-1:0]           in_channel,
  input  logic signed [SMP_W-1:0]   in_left_in,
  input  logic signed [SMP_W-1:0]   in_right_in,
  input  logic                      in_sample_end,
  input  logic                      in_frame_end,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [KIND_W-1:0]         out_kind,
  input  logic [CH_W-1:0]           out_report_channel,
  input  logic signed [OUT_W-1:0]   out_left_out,
  input  logic signed [OUT_W-1:0]   out_right_out,
  input  logic                      out_last,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        results_due
);

  localparam int NCH          = DEF_MAX_CHANNELS;
  localparam int TBL          = DEF_PAN_TABLE_SIZE;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    kind_t                   kind;
    logic [CH_W-1:0]         chan;
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    last;
  } mix_result_t;

  int unsigned sine_lut [0:TBL];

  logic [ACT_W-1:0]      active_cnt;
  logic [MASK_W-1:0]     mute_bits;
  logic [MASK_W-1:0]     solo_bits;
  logic [CFG_DATA_W-1:0] vol_bytes;
  logic [CFG_DATA_W-1:0] pan_bytes;
  logic [VOL_W-1:0]      master_gain;

  longint sum_l, sum_r;
  longint chan_pk_l [NCH];
  longint chan_pk_r [NCH];
  longint master_pk_l, master_pk_r;

  mix_result_t mixer_outputs_due [$];

  // Quarter sine in Q1.15, built by the same integer Taylor series in Q2.30
  // that the hardware table is generated from.
  initial begin : build_sine
    longint unsigned x, x2, term;
    longint acc;
    for (int k = 0; k <= TBL; k++) begin
      x = longint'(k) * 64'd1686629713 / TBL;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc + 16384) >>> 15;
      sine_lut[k] = (acc > 32768) ? 32768 : int'(acc);
    end
  end

  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint abs_peak(longint v);
    longint a;
    a = (v < 0) ? -v : v;
    return (a > 32768) ? 64'sd32768 : a;
  endfunction

  // Channels beyond the active count, muted ones, and unsoloed ones while a
  // solo is set below the active count are left out of the mix.
  function automatic bit chan_silent(int c);
    int lim;
    bit any_solo;
    lim = (int'(active_cnt) > NCH) ? NCH : int'(active_cnt);
    if (c >= lim) return 1'b1;
    if (mute_bits[c]) return 1'b1;
    any_solo = (int'(solo_bits) & ((1 << lim) - 1)) != 0;
    return any_solo && !solo_bits[c];
  endfunction

  task automatic mix_channel_item(input int ch, input longint l, input longint r,
                                  input bit se, input bit fe);
    longint vol, gain_l, gain_r, sl, sr, ml, mr, pl, pr;
    int pan, k;
    if (!chan_silent(ch)) begin
      vol = longint'(vol_bytes[8*ch +: 8]);
      pan = int'($signed(pan_bytes[8*ch +: 8]));
      k = ((pan + 128) * TBL) >> 8;
      gain_l = vol * longint'(sine_lut[TBL - k]);
      gain_r = vol * longint'(sine_lut[k]);
      sl = round_half_up(l * gain_l, 22);
      sr = round_half_up(r * gain_r, 22);
      sum_l = clip(sum_l + sl, -64'sd8388608, 64'sd8388607);
      sum_r = clip(sum_r + sr, -64'sd8388608, 64'sd8388607);
      if (abs_peak(sl) > chan_pk_l[ch]) chan_pk_l[ch] = abs_peak(sl);
      if (abs_peak(sr) > chan_pk_r[ch]) chan_pk_r[ch] = abs_peak(sr);
    end
    if (!se) return;

    ml = clip(round_half_up(sum_l * longint'(master_gain), 7), -64'sd32768, 64'sd32767);
    mr = clip(round_half_up(sum_r * longint'(master_gain), 7), -64'sd32768, 64'sd32767);
    sum_l = 0;
    sum_r = 0;
    if (abs_peak(ml) > master_pk_l) master_pk_l = abs_peak(ml);
    if (abs_peak(mr) > master_pk_r) master_pk_r = abs_peak(mr);
    mixer_outputs_due.push_back('{KIND_MIX, '0, OUT_W'(ml), OUT_W'(mr), !fe});
    if (!fe) return;

    for (int c = 0; c < NCH; c++) begin
      pl = chan_silent(c) ? 0 : chan_pk_l[c];
      pr = chan_silent(c) ? 0 : chan_pk_r[c];
      mixer_outputs_due.push_back('{KIND_CHAN, CH_W'(c), OUT_W'(pl), OUT_W'(pr), 1'b0});
      chan_pk_l[c] = 0;
      chan_pk_r[c] = 0;
    end
    mixer_outputs_due.push_back('{KIND_MASTER, '0, OUT_W'(master_pk_l),
                                  OUT_W'(master_pk_r), 1'b1});
    master_pk_l = 0;
    master_pk_r = 0;
  endtask

  always @(posedge clk) begin : watch
    mix_result_t want;
    if (!rst_n) begin
      active_cnt  = RST_ACTIVE;
      mute_bits   = '0;
      solo_bits   = '0;
      vol_bytes   = RST_VOLUMES;
      pan_bytes   = RST_PANS;
      master_gain = RST_MASTER;
      sum_l = 0;
      sum_r = 0;
      for (int c = 0; c < NCH; c++) begin
        chan_pk_l[c] = 0;
        chan_pk_r[c] = 0;
      end
      master_pk_l = 0;
      master_pk_r = 0;
      mixer_outputs_due.delete();
      fail_count = 0;
    end else begin
      // Results are checked before this edge's input item is added, so a
      // result arriving with nothing queued is always caught.
      if (out_valid && !out_stall) begin
        if (mixer_outputs_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result kind=%0d chan=%0d left=%0d right=%0d last=%0b",
                     $time, out_kind, out_report_channel, out_left_out, out_right_out,
                     out_last);
        end else begin
          want = mixer_outputs_due.pop_front();
          if (out_kind !== want.kind || out_report_channel !== want.chan ||
              out_left_out !== want.left || out_right_out !== want.right ||
              out_last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected kind=%0d chan=%0d left=%0d right=%0d last=%0b",
                       want.kind, want.chan, want.left, want.right, want.last);
              $display("  actual   kind=%0d chan=%0d left=%0d right=%0d last=%0b",
                       out_kind, out_report_channel, out_left_out, out_right_out,
                       out_last);
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE:  active_cnt  = cfg_data[ACT_W-1:0];
          REG_MUTE:    mute_bits   = cfg_data[MASK_W-1:0];
          REG_SOLO:    solo_bits   = cfg_data[MASK_W-1:0];
          REG_VOLUMES: vol_bytes   = cfg_data;
          REG_PANS:    pan_bytes   = cfg_data;
          REG_MASTER:  master_gain = cfg_data[VOL_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        mix_channel_item(int'(in_channel), longint'(in_left_in), longint'(in_right_in),
                         in_sample_end, in_frame_end);
    end
    results_due <= mixer_outputs_due.size();
  end

endmodule

@@ dv/stereo_channel_mixer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_channel_mixer_unit_tb
// Drives channel items and register writes into the stereo channel mixer and
// gives the verdict from the failure count of the checker beside it.
// ----------------------------------------------------------------------------
// A directed part walks the pan and volume extremes, mute, solo and the
// active count, frame end with and without sample end, and a short run of
// full-scale items that drives the channel peaks into saturation. Random
// frames follow under three pacing modes. Registers are only rewritten once
// every expected result has come back and the block has had time to finish
// any item that produces no result.
// ----------------------------------------------------------------------------

module stereo_channel_mixer_unit_tb;
  import scm_pkg::*;

  localparam int NCH            = DEF_MAX_CHANNELS;
  // Long receiver hold-off that lets the block fill up and stall its input.
  localparam int HOLD_CYCLES    = 300;
  // Ample time for the block to finish an item or a frame end.
  localparam int DRAIN_CYCLES   = 40;
  // Ten results each waiting out the longest stall, with ample margin.
  localparam int STALL_LIMIT    = 20000;
  localparam int RANDOM_ITEMS   = 22;
  // A few full-scale pairs push both channel peaks past their limit.
  localparam int PEAK_ITEMS     = 3;

  localparam logic signed [SMP_W-1:0] SMP_MAX     = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN     = 16'sh8000;
  localparam logic [CFG_DATA_W-1:0]   VOL_ALL_MAX = '1;
  // An index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0]    REG_SPARE   = 3'd7;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic [CH_W-1:0]         in_channel    = '0;
  logic signed [SMP_W-1:0] in_left_in    = '0;
  logic signed [SMP_W-1:0] in_right_in   = '0;
  logic                    in_sample_end = 1'b0;
  logic                    in_frame_end  = 1'b0;
  logic                    out_stall     = 1'b0;
  logic                    cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_data      = '0;

  logic                    in_stall;
  logic                    out_valid;
  logic [KIND_W-1:0]       out_kind;
  logic [CH_W-1:0]         out_report_channel;
  logic signed [OUT_W-1:0] out_left_out;
  logic signed [OUT_W-1:0] out_right_out;
  logic                    out_last;
  logic                    cfg_ready;

  int fail_count;
  int results_due;

  // Pacing: percentage of cycles in which each side holds back.
  int send_idle = 0;
  int recv_idle = 0;

  // Hold-off requests from the stimulus, served by the receiver process.
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  int quiet = 0;

  stereo_channel_mixer_unit uut (.*);

  stereo_channel_mixer_unit_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_reqs;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Watchdog: the run is stuck if no channel moves anything for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one item, possibly after some idle cycles, and returns at the edge
  // where it is taken. Valid stays high so that back-to-back items need no
  // second assignment in the same step.
  task automatic offer_item(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] l,
                            input logic signed [SMP_W-1:0] r, input logic se,
                            input logic fe);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_channel    <= ch;
    in_left_in    <= l;
    in_right_in   <= r;
    in_sample_end <= se;
    in_frame_end  <= fe;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register in turn, plus the unused index with random data.
  task automatic apply_settings(input logic [ACT_W-1:0] act, input logic [MASK_W-1:0] mute,
                                input logic [MASK_W-1:0] solo,
                                input logic [CFG_DATA_W-1:0] vols,
                                input logic [CFG_DATA_W-1:0] pans,
                                input logic [VOL_W-1:0] master);
    cfg_put(REG_ACTIVE, CFG_DATA_W'(act));
    cfg_put(REG_MUTE, CFG_DATA_W'(mute));
    cfg_put(REG_SOLO, CFG_DATA_W'(solo));
    cfg_put(REG_VOLUMES, vols);
    cfg_put(REG_PANS, pans);
    cfg_put(REG_MASTER, CFG_DATA_W'(master));
    cfg_put(REG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Random settings, with the usual values favored so that most channels
  // are heard.
  task automatic rand_settings();
    logic [ACT_W-1:0]  act;
    logic [MASK_W-1:0] mute;
    logic [MASK_W-1:0] solo;
    logic [VOL_W-1:0]  master;
    act    = ($urandom_range(0, 1) == 0) ? ACT_W'(NCH) : ACT_W'($urandom_range(0, 15));
    mute   = ($urandom_range(0, 1) == 0) ? '0 : MASK_W'($urandom & $urandom);
    solo   = ($urandom_range(0, 2) == 0) ? MASK_W'($urandom & $urandom) : '0;
    master = ($urandom_range(0, 1) == 0) ? RST_MASTER : VOL_W'($urandom_range(0, 255));
    apply_settings(act, mute, solo, {$urandom, $urandom}, {$urandom, $urandom}, master);
  endtask

  // Stops offering, waits for every queued result, then gives the block time
  // to finish an item that produces no result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // One item per channel from 0 up, alternating full-scale polarity, closing
  // the sample time and the frame on the last one.
  task automatic sweep_frame(input int n_ch);
    for (int c = 0; c < n_ch; c++)
      offer_item(CH_W'(c), (c % 2 == 1) ? SMP_MIN : SMP_MAX,
                 (c % 2 == 1) ? SMP_MAX : SMP_MIN, c == n_ch - 1, c == n_ch - 1);
  endtask

  // Mostly well-formed sample times of random length and content; the rest
  // are single items with random flags.
  task automatic mix_random(input int n_items);
    int sent;
    int n;
    bit fe;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        n  = $urandom_range(1, NCH);
        fe = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
          offer_item(CH_W'($urandom_range(0, NCH - 1)), rand_sample(), rand_sample(),
                     i == n - 1, (i == n - 1) ? fe : 1'($urandom_range(0, 1)));
        sent += n;
      end else begin
        offer_item(CH_W'($urandom_range(0, NCH - 1)), rand_sample(), rand_sample(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    send_idle <= 30;
    recv_idle <= 88;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Full volume and the pan extremes, master at its maximum. The second
    // item carries frame end without sample end, which must be ignored.
    apply_settings(4'd8, 8'h00, 8'h00, VOL_ALL_MAX, 64'h81FF_0140_C000_7F80, 8'hFF);
    offer_item(3'd0, SMP_MAX, SMP_MIN, 1'b0, 1'b0);
    offer_item(3'd1, SMP_MIN, SMP_MAX, 1'b0, 1'b1);
    offer_item(3'd2, 16'sd0, 16'sd0, 1'b1, 1'b0);
    offer_item(3'd3, SMP_MAX, SMP_MAX, 1'b1, 1'b0);
    offer_item(3'd4, SMP_MIN, SMP_MIN, 1'b0, 1'b0);
    offer_item(3'd5, 16'sd1, -16'sd1, 1'b0, 1'b0);
    offer_item(3'd6, 16'sh5555, 16'shAAAA, 1'b0, 1'b0);
    offer_item(3'd7, SMP_MIN, SMP_MAX, 1'b1, 1'b1);
    wait_drained();

    // Five active channels, one muted, zero volume on some, near-zero master.
    apply_settings(4'd5, 8'h04, 8'h00, 64'h00FF_7F80_0001_40FF, 64'h0, 8'h01);
    sweep_frame(NCH);
    wait_drained();

    // Active count above the channel count, two soloed channels of which one
    // is also muted, master at zero.
    apply_settings(4'd15, 8'h20, 8'hA0, VOL_ALL_MAX, 64'h7F80_7F80_7F80_7F80, 8'h00);
    sweep_frame(NCH);
    wait_drained();

    // A solo above the active count does not silence the active channels.
    apply_settings(4'd3, 8'h00, 8'h80, RST_VOLUMES, RST_PANS, RST_MASTER);
    sweep_frame(4);
    wait_drained();

    // No active channel at all: everything is silent.
    apply_settings(4'd0, 8'hFF, 8'hFF, RST_VOLUMES, '1, 8'hFF);
    sweep_frame(2);
    wait_drained();

    // Channel 0 panned hard left and channel 1 hard right at full volume:
    // full-scale items push the channel peaks to their limit and the mixed
    // output into saturation.
    apply_settings(4'd2, 8'h00, 8'h00, VOL_ALL_MAX, 64'h0000_0000_0000_7F80, RST_MASTER);
    for (int i = 0; i < PEAK_ITEMS; i++) begin
      offer_item(3'd0, SMP_MAX, SMP_MAX, 1'b0, 1'b0);
      offer_item(3'd1, SMP_MIN, SMP_MIN, 1'b0, 1'b0);
    end
    offer_item(3'd0, SMP_MAX, SMP_MIN, 1'b1, 1'b1);
    wait_drained();

    // Random frames, first with a long receiver hold-off at the start while
    // items keep coming.
    rand_settings();
    hold_reqs <= hold_reqs + 1;
    mix_random(RANDOM_ITEMS);
    wait_drained();

    send_idle <= 88;
    recv_idle <= 30;
    rand_settings();
    mix_random(RANDOM_ITEMS);
    wait_drained();

    send_idle <= 0;
    recv_idle <= 0;
    rand_settings();
    hold_reqs <= hold_reqs + 1;
    mix_random(RANDOM_ITEMS);
    wait_drained();

    if (fail_count == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/scm_pkg.sv
rtl/scm_gain_rom.sv
rtl/stereo_channel_mixer_unit.sv
dv/stereo_channel_mixer_unit_checker.sv
dv/stereo_channel_mixer_unit_tb.sv
